>>> design/bed_pkg.sv
// Shared types and constants of the button event detector.
package bed_pkg;

    localparam int TIME_W = 32;
    localparam int PARM_W = 16;
    localparam int CNT_W  = 16;
    localparam int IDX_W  = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [IDX_W-1:0] REG_INVERT      = 3'd1;
    localparam logic [IDX_W-1:0] REG_UPDATE_INT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIN_PUSH    = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_RELEASE = 3'd4;
    localparam logic [IDX_W-1:0] REG_DOUBLE_SPAN = 3'd5;
    localparam logic [IDX_W-1:0] REG_HOLD_INT    = 3'd6;

    // Reset values of the configuration registers
    localparam logic [PARM_W-1:0] RST_UPDATE_INT  = 16'd32;
    localparam logic [PARM_W-1:0] RST_MIN_PUSH    = 16'd40;
    localparam logic [PARM_W-1:0] RST_MIN_RELEASE = 16'd40;
    localparam logic [PARM_W-1:0] RST_DOUBLE_SPAN = 16'd500;
    localparam logic [PARM_W-1:0] RST_HOLD_INT    = 16'd250;

    typedef struct packed {
        logic              enable;
        logic              invert;
        logic [PARM_W-1:0] update_interval;
        logic [PARM_W-1:0] min_push_time;
        logic [PARM_W-1:0] min_release_time;
        logic [PARM_W-1:0] double_span;
        logic [PARM_W-1:0] hold_interval;
    } t_cfg;

    typedef struct packed {
        logic              pressed;
        logic              push_event;
        logic              release_event;
        logic              click_event;
        logic              double_event;
        logic              hold_event;
        logic [CNT_W-1:0]  click_total;
        logic [TIME_W-1:0] press_age;
    } t_result;

endpackage

>>> design/bed_cfg.sv
// Configuration register file of the button event detector.
module bed_cfg
    import bed_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [PARM_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable           <= 1'b1;
            r_cfg.invert           <= 1'b0;
            r_cfg.update_interval  <= RST_UPDATE_INT;
            r_cfg.min_push_time    <= RST_MIN_PUSH;
            r_cfg.min_release_time <= RST_MIN_RELEASE;
            r_cfg.double_span      <= RST_DOUBLE_SPAN;
            r_cfg.hold_interval    <= RST_HOLD_INT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE:      r_cfg.enable           <= i_cfg_data[0];
                REG_INVERT:      r_cfg.invert           <= i_cfg_data[0];
                REG_UPDATE_INT:  r_cfg.update_interval  <= i_cfg_data;
                REG_MIN_PUSH:    r_cfg.min_push_time    <= i_cfg_data;
                REG_MIN_RELEASE: r_cfg.min_release_time <= i_cfg_data;
                REG_DOUBLE_SPAN: r_cfg.double_span      <= i_cfg_data;
                REG_HOLD_INT:    r_cfg.hold_interval    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> design/bed_engine.sv
// Tick state and event logic of the button event detector: one tick per step.
module bed_engine
    import bed_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_level,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_last_sample, n_last_sample;
    logic              r_pressed, n_pressed;
    logic [TIME_W-1:0] r_press_start, n_press_start;
    logic [TIME_W-1:0] r_release_at, n_release_at;
    logic [TIME_W-1:0] r_prev_press, n_prev_press;
    logic [TIME_W-1:0] r_prev_release, n_prev_release;
    logic [TIME_W-1:0] r_hold_mark, n_hold_mark;
    logic              r_rel_pending, n_rel_pending;
    logic              r_holding, n_holding;
    logic [CNT_W-1:0]  r_clicks, n_clicks;

    // values after the sampling step
    logic [TIME_W-1:0] smp_press_start, smp_release_at, smp_prev_press, smp_prev_release;
    logic [TIME_W-1:0] smp_hold_mark;
    logic              smp_pressed, smp_rel_pending, smp_holding_pre;

    logic sample, lvl, push_ev, rel_ev, hold_ev, click_q, dbl_ev, click_ev;

    always_comb begin
        lvl    = i_level ^ i_cfg.invert;
        sample = i_cfg.enable &&
                 ((r_now - r_last_sample) >= {16'd0, i_cfg.update_interval});

        n_last_sample    = sample ? r_now : r_last_sample;
        smp_pressed      = r_pressed;
        smp_press_start  = r_press_start;
        smp_release_at   = r_release_at;
        smp_prev_press   = r_prev_press;
        smp_prev_release = r_prev_release;
        smp_hold_mark    = r_hold_mark;
        smp_rel_pending  = r_rel_pending;
        smp_holding_pre  = r_holding;
        push_ev          = 1'b0;
        rel_ev           = 1'b0;

        if (sample) begin
            if (lvl && !r_pressed) begin
                smp_pressed      = 1'b1;
                smp_prev_press   = r_press_start;
                smp_prev_release = r_release_at;
                smp_press_start  = r_now;
                smp_hold_mark    = r_now;
                smp_holding_pre  = 1'b0;
                push_ev          = 1'b1;
            end else if (!lvl && r_pressed) begin
                smp_pressed     = 1'b0;
                smp_release_at  = r_now;
                smp_rel_pending = 1'b1;
                rel_ev          = 1'b1;
            end
        end

        hold_ev = smp_pressed &&
                  ((r_now - smp_hold_mark) >= {16'd0, i_cfg.hold_interval});
        n_hold_mark = hold_ev ? r_now : smp_hold_mark;
        n_holding   = smp_holding_pre | hold_ev;

        click_q = !n_holding
               && ((r_now - smp_press_start) >= {16'd0, i_cfg.min_push_time})
               && ((r_now - smp_release_at) >= {16'd0, i_cfg.min_release_time})
               && smp_rel_pending
               && (smp_press_start < smp_release_at);

        dbl_ev = ((smp_prev_release - smp_prev_press) >= {16'd0, i_cfg.min_push_time})
              && ((r_now - smp_prev_press) <= {16'd0, i_cfg.double_span})
              && ((r_now - smp_prev_release) >= {16'd0, i_cfg.min_release_time})
              && click_q;
        // a double click clears the pending release, so no plain click follows
        click_ev = click_q && !dbl_ev;

        n_pressed      = smp_pressed;
        n_release_at   = smp_release_at;
        n_prev_press   = smp_prev_press;
        n_prev_release = smp_prev_release;
        n_press_start  = dbl_ev ? '0 : smp_press_start;
        n_rel_pending  = smp_rel_pending && !click_q;
        n_clicks       = click_q ? r_clicks + CNT_W'(1) : r_clicks;
        n_now          = r_now + TIME_W'(1);

        o_result.pressed       = n_pressed;
        o_result.push_event    = push_ev;
        o_result.release_event = rel_ev;
        o_result.click_event   = click_ev;
        o_result.double_event  = dbl_ev;
        o_result.hold_event    = hold_ev;
        o_result.click_total   = n_clicks;
        o_result.press_age     = r_now - n_press_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now          <= '0;
            r_last_sample  <= '0;
            r_pressed      <= 1'b0;
            r_press_start  <= '0;
            r_release_at   <= '0;
            r_prev_press   <= '0;
            r_prev_release <= '0;
            r_hold_mark    <= '0;
            r_rel_pending  <= 1'b0;
            r_holding      <= 1'b0;
            r_clicks       <= '0;
        end else if (i_step) begin
            r_now          <= n_now;
            r_last_sample  <= n_last_sample;
            r_pressed      <= n_pressed;
            r_press_start  <= n_press_start;
            r_release_at   <= n_release_at;
            r_prev_press   <= n_prev_press;
            r_prev_release <= n_prev_release;
            r_hold_mark    <= n_hold_mark;
            r_rel_pending  <= n_rel_pending;
            r_holding      <= n_holding;
            r_clicks       <= n_clicks;
        end
    end

endmodule

>>> design/button_event_detector.sv
// Top level of the button event detector: input register, tick engine, result register.
// Each input word is one millisecond tick carrying the raw button level; every accepted
// word yields exactly one result word with the debounced state, the push, release, click,
// double-click and hold events of that tick, the click count and the age of the current
// press. A word is accepted every clock cycle when the output side keeps up. A result
// word passes through the input register, and the single-pass state update writes it
// into the result register. While a result word is stalled, the input register holds
// its word, and the input stalls once both registers are full. Configuration registers
// are written through the cfg channel, which is always ready; the user must write them
// only while no ticks are in flight, as the block itself does not enforce this.
module button_event_detector
    import bed_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_level,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_pressed,
    output logic              o_push_event,
    output logic              o_release_event,
    output logic              o_click_event,
    output logic              o_double_event,
    output logic              o_hold_event,
    output logic [CNT_W-1:0]  o_click_total,
    output logic [TIME_W-1:0] o_press_age,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [PARM_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    r_in_valid;
    logic    r_in_level;
    logic    advance;

    // advance the held word when the result register is free or being taken
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    bed_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bed_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_level  (r_in_level),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_level <= i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pressed       = r_out.pressed;
    assign o_push_event    = r_out.push_event;
    assign o_release_event = r_out.release_event;
    assign o_click_event   = r_out.click_event;
    assign o_double_event  = r_out.double_event;
    assign o_hold_event    = r_out.hold_event;
    assign o_click_total   = r_out.click_total;
    assign o_press_age     = r_out.press_age;

endmodule
